// File: hw/rtl/line_angle_pid_steer_core_assert.svh
// Assertion macros for the line angle PID steering checker
`ifndef LINE_ANGLE_PID_STEER_CORE_ASSERT_SVH
`define LINE_ANGLE_PID_STEER_CORE_ASSERT_SVH

// Checked on every rising edge outside reset
`define LAPID_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included
`define LAPID_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: hw/rtl/lapid_pkg.sv
// Types and constants for the line angle PID steering controller
`timescale 1ns / 1ps

package lapid_pkg;

  // Fixed-point format of gains and correction
  localparam int FRAC_BITS = 8;
  localparam int CORR_W    = 17;
  localparam int ANGLE_W   = 9;
  localparam int SUM_W     = 13;
  localparam int DIFF_W    = ANGLE_W + 1;
  localparam int GAIN_W    = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  // Accumulator: widest product (13 x 13 bits) plus two guard bits
  localparam int ACC_W     = GAIN_W + 1 + SUM_W + 2;
  localparam int OLIM_W    = 8 + FRAC_BITS;

  // 1.0 in the correction format
  localparam logic signed [ACC_W-1:0] ONE_Q = ACC_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_HOVER = 2'd1,
    ACT_MOVE  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    HEAD_FWD   = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_LEFT  = 2'd2
  } heading_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_DEAD_ZONE = 3'd3,
    CFG_INT_LIMIT = 3'd4,
    CFG_OUT_LIMIT = 3'd5,
    CFG_SKIP      = 3'd6
  } cfg_idx_t;

  // Controller step handed from the state stage to the arithmetic stage
  typedef struct packed {
    action_t                    action;
    logic signed [ANGLE_W-1:0]  err;
    logic signed [SUM_W-1:0]    sum;
    logic signed [DIFF_W-1:0]   diff;
  } step_t;

endpackage

// File: hw/rtl/lapid_calc.sv
// PID sum, output saturation and heading quantisation
`timescale 1ns / 1ps

module lapid_calc (
  input  lapid_pkg::step_t                   step,
  input  logic [lapid_pkg::GAIN_W-1:0]       gain_p,
  input  logic [lapid_pkg::GAIN_W-1:0]       gain_i,
  input  logic [lapid_pkg::GAIN_W-1:0]       gain_d,
  input  logic [7:0]                         output_limit,
  output logic signed [lapid_pkg::CORR_W-1:0] correction,
  output lapid_pkg::heading_t                heading
);

  localparam int PW = lapid_pkg::GAIN_W + 1 + lapid_pkg::ANGLE_W;
  localparam int IW = lapid_pkg::GAIN_W + 1 + lapid_pkg::SUM_W;
  localparam int DW = lapid_pkg::GAIN_W + 1 + lapid_pkg::DIFF_W;
  localparam int AW = lapid_pkg::ACC_W;

  logic signed [PW-1:0] prod_p;
  logic signed [IW-1:0] prod_i;
  logic signed [DW-1:0] prod_d;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] olim;
  logic signed [AW-1:0] sat;

  // Three products in parallel, gains taken as positive signed values
  assign prod_p = $signed({1'b0, gain_p}) * step.err;
  assign prod_i = $signed({1'b0, gain_i}) * step.sum;
  assign prod_d = $signed({1'b0, gain_d}) * step.diff;

  assign acc = AW'(prod_p) + AW'(prod_i) + AW'(prod_d);

  // Limit in Q.FRAC_BITS
  assign olim = $signed(AW'({output_limit, {lapid_pkg::FRAC_BITS{1'b0}}}));

  // Saturate and quantise; non-move steps report zero and forward
  always_comb begin
    if (acc > olim) begin
      sat = olim;
    end else if (acc < -olim) begin
      sat = -olim;
    end else begin
      sat = acc;
    end

    if (step.action != lapid_pkg::ACT_MOVE) begin
      correction = '0;
      heading    = lapid_pkg::HEAD_FWD;
    end else begin
      correction = lapid_pkg::CORR_W'(sat);
      if (sat > lapid_pkg::ONE_Q) begin
        heading = lapid_pkg::HEAD_RIGHT;
      end else if (sat < -lapid_pkg::ONE_Q) begin
        heading = lapid_pkg::HEAD_LEFT;
      end else begin
        heading = lapid_pkg::HEAD_FWD;
      end
    end
  end

endmodule

// File: hw/rtl/line_angle_pid_steer_core.sv
// Line angle PID steering controller: top level
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: in_func (0 tick,
//   1 clear), in_angle (signed degrees) and in_line_present. Every item
//   yields exactly one result on the output channel (out_valid / out_stall):
//   out_action, out_correction (signed Q.8 degrees) and out_heading.
//   Ticks are decimated by skip_ticks; a running tick without a line
//   clears the controller and reports hover.
//   Configuration writes go through cfg_valid / cfg_ready with cfg_index
//   and cfg_data; cfg_ready is always high. Write only while idle.
//   The item passes the input register, the state stage register and the
//   result register before out_valid rises. Throughput: one item per
//   cycle while no held result stalls the pipeline, set by the
//   error_sum / prior_error / tick_count update loop.
//   Reset (rst_n low, synchronous) empties the pipeline, clears the
//   controller state and loads the default register values.
//   When out_stall is high with a result pending the whole pipeline holds
//   and in_stall rises in the same cycle; no item is lost or repeated.

module line_angle_pid_steer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input item channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic signed [lapid_pkg::ANGLE_W-1:0]  in_angle,
  input  logic                                  in_line_present,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_action,
  output logic signed [lapid_pkg::CORR_W-1:0]   out_correction,
  output logic [1:0]                            out_heading,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lapid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lapid_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW = lapid_pkg::ANGLE_W;
  localparam int SW = lapid_pkg::SUM_W;

  // Configuration registers
  logic [lapid_pkg::GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r, int_limit_r;
  logic [7:0]                   dead_zone_r, out_limit_r, skip_ticks_r;

  // Controller state
  logic signed [SW-1:0] error_sum_r, error_sum_nxt;
  logic signed [AW-1:0] prior_error_r, prior_error_nxt;
  logic [7:0]           tick_count_r, tick_count_nxt;

  // Pipeline
  logic                 adv;
  logic                 s1_valid_r;
  logic                 s1_func_r;
  logic signed [AW-1:0] s1_angle_r;
  logic                 s1_line_r;
  logic                 s2_valid_r;
  lapid_pkg::step_t     s2_r, s2_nxt;
  logic                 out_valid_r;
  lapid_pkg::action_t   out_action_r;
  lapid_pkg::heading_t  out_heading_r, calc_heading;
  logic signed [lapid_pkg::CORR_W-1:0] out_corr_r, calc_corr;

  // State-stage working values
  logic signed [AW:0]   err_ext, dz_pos;
  logic signed [AW-1:0] err_dz;
  logic signed [SW:0]   sum_raw, ilim;
  logic signed [SW-1:0] sum_clamp;

  // Whole pipeline moves unless a pending result is held off
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= 12'd256;
      gain_i_r     <= 12'd0;
      gain_d_r     <= 12'd51;
      dead_zone_r  <= 8'd2;
      int_limit_r  <= 12'd30;
      out_limit_r  <= 8'd30;
      skip_ticks_r <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lapid_pkg::CFG_GAIN_P:    gain_p_r     <= cfg_data;
        lapid_pkg::CFG_GAIN_I:    gain_i_r     <= cfg_data;
        lapid_pkg::CFG_GAIN_D:    gain_d_r     <= cfg_data;
        lapid_pkg::CFG_DEAD_ZONE: dead_zone_r  <= cfg_data[7:0];
        lapid_pkg::CFG_INT_LIMIT: int_limit_r  <= cfg_data;
        lapid_pkg::CFG_OUT_LIMIT: out_limit_r  <= cfg_data[7:0];
        lapid_pkg::CFG_SKIP:      skip_ticks_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Dead zone and clamped error sum
  assign err_ext = (AW+1)'(s1_angle_r);
  assign dz_pos  = $signed({1'b0, dead_zone_r});
  assign err_dz  = (err_ext > -dz_pos && err_ext < dz_pos) ? '0 : s1_angle_r;
  assign sum_raw = (SW+1)'(error_sum_r) + (SW+1)'(err_dz);
  assign ilim    = $signed((SW+1)'({1'b0, int_limit_r}));

  always_comb begin
    if (sum_raw > ilim) begin
      sum_clamp = SW'(ilim);
    end else if (sum_raw < -ilim) begin
      sum_clamp = SW'(-ilim);
    end else begin
      sum_clamp = SW'(sum_raw);
    end
  end

  // Decimation and controller state update
  always_comb begin
    error_sum_nxt   = error_sum_r;
    prior_error_nxt = prior_error_r;
    tick_count_nxt  = tick_count_r;
    s2_nxt.action   = lapid_pkg::ACT_NONE;
    s2_nxt.err      = err_dz;
    s2_nxt.sum      = sum_clamp;
    s2_nxt.diff     = (AW+1)'(err_dz) - (AW+1)'(prior_error_r);
    if (s1_func_r) begin
      error_sum_nxt   = '0;
      prior_error_nxt = '0;
    end else if (tick_count_r < skip_ticks_r) begin
      tick_count_nxt = tick_count_r + 8'd1;
    end else begin
      tick_count_nxt = '0;
      if (!s1_line_r) begin
        error_sum_nxt   = '0;
        prior_error_nxt = '0;
        s2_nxt.action   = lapid_pkg::ACT_HOVER;
      end else begin
        error_sum_nxt   = sum_clamp;
        prior_error_nxt = err_dz;
        s2_nxt.action   = lapid_pkg::ACT_MOVE;
      end
    end
  end

  // Control: valid bits and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      error_sum_r   <= '0;
      prior_error_r <= '0;
      tick_count_r  <= '0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      if (s1_valid_r) begin
        error_sum_r   <= error_sum_nxt;
        prior_error_r <= prior_error_nxt;
        tick_count_r  <= tick_count_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r     <= in_func;
      s1_angle_r    <= in_angle;
      s1_line_r     <= in_line_present;
      s2_r          <= s2_nxt;
      out_action_r  <= s2_r.action;
      out_corr_r    <= calc_corr;
      out_heading_r <= calc_heading;
    end
  end

  lapid_calc u_calc (
    .step         (s2_r),
    .gain_p       (gain_p_r),
    .gain_i       (gain_i_r),
    .gain_d       (gain_d_r),
    .output_limit (out_limit_r),
    .correction   (calc_corr),
    .heading      (calc_heading)
  );

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_correction = out_corr_r;
  assign out_heading    = out_heading_r;

endmodule

// File: hw/rtl/lapid_check.sv
// Port-level checks for the line angle PID steering controller, with bind
`timescale 1ns / 1ps
`include "line_angle_pid_steer_core_assert.svh"

module lapid_check (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_func,
  input logic signed [lapid_pkg::ANGLE_W-1:0] in_angle,
  input logic                                 in_line_present,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [1:0]                           out_action,
  input logic signed [lapid_pkg::CORR_W-1:0]  out_correction,
  input logic [1:0]                           out_heading,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [lapid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [lapid_pkg::CFG_W-1:0]          cfg_data
);

  // A held result stays offered
  `LAPID_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid)

  // Input side backs up exactly when a pending result is held off
  `LAPID_ASSERT_RST(a_stall_link, in_stall == (out_valid && out_stall))

  // Skipped, cleared and hover items carry no correction
  `LAPID_ASSERT_RST(a_idle_zero, out_valid && out_action != lapid_pkg::ACT_MOVE |-> out_correction == '0 && out_heading == lapid_pkg::HEAD_FWD)

  // Right turn only on a positive correction
  `LAPID_ASSERT_RST(a_head_sign, out_valid && out_heading == lapid_pkg::HEAD_RIGHT |-> !out_correction[lapid_pkg::CORR_W-1] && out_correction != '0)

endmodule

bind line_angle_pid_steer_core lapid_check u_lapid_check (.*);
